/* design/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, suspended while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must hold at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/itp_pkg.sv */
// Shared types, character codes and helpers for the infix to postfix converter.
`default_nettype none
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_LET_LO = 8'h61;
  localparam logic [7:0] CH_LET_HI = 8'h7A;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_LETTER,
    K_OPEN,
    K_CLOSE,
    K_MULDIV,
    K_ADDSUB,
    K_OTHER
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_READ,
    S_TEST,
    S_FLUSH_READ,
    S_FLUSH_TEST,
    S_DONE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       sym_valid;
    logic       done;
    status_t    status;
  } result_t;

  // Request from the sequencer to the output stage.
  typedef struct packed {
    logic    produce;
    logic    finish;
    result_t res;
  } emit_req_t;

  // Output stage occupancy seen by the sequencer.
  typedef struct packed {
    logic hold_valid;
    logic can_emit;
  } emit_stat_t;

  function automatic kind_t classify(input logic [7:0] c);
    kind_t k;
    if (c >= CH_LET_LO && c <= CH_LET_HI) k = K_LETTER;
    else if (c == CH_OPEN)                k = K_OPEN;
    else if (c == CH_CLOSE)               k = K_CLOSE;
    else if (c == CH_MUL || c == CH_DIV)  k = K_MULDIV;
    else if (c == CH_ADD || c == CH_SUB)  k = K_ADDSUB;
    else                                  k = K_OTHER;
    return k;
  endfunction

endpackage
`default_nettype wire

/* design/itp_stack_mem.sv */
// Operator stack storage: one write port, one read port with registered data.
`default_nettype none
module itp_stack_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no new read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/itp_out_stage.sv */
// Output stage: a hold register that learns whether its result is the item's last,
// followed by the stream output register.
`default_nettype none
module itp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire itp_pkg::emit_req_t req,
  output itp_pkg::emit_stat_t     stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output itp_pkg::result_t        out_res,
  output logic                    out_last
);
  import itp_pkg::*;

  logic    hold_valid;
  result_t hold;
  logic    can_emit;
  logic    move;

  assign can_emit        = !out_valid || out_ready;
  assign stat.hold_valid = hold_valid;
  assign stat.can_emit   = can_emit;

  // A newer result means the held one is not the last of its item; at the finish
  // request the held result is the last one.
  assign move = hold_valid && (req.produce || (req.finish && can_emit));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
        out_res   <= hold;
        out_last  <= !req.produce;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (req.produce) begin
        hold       <= req.res;
        hold_valid <= 1'b1;
      end else if (move) begin
        hold_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* design/itp_ctrl.sv */
// Sequencer: classifies each character and walks the operator stack in memory.
`default_nettype none
module itp_ctrl #(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_symbol,
  input  wire logic                in_end,
  output logic                     wr_en,
  output logic      [AW-1:0]       wr_addr,
  output logic      [7:0]          wr_data,
  output logic                     rd_en,
  output logic      [AW-1:0]       rd_addr,
  input  wire logic [7:0]          rd_data,
  output itp_pkg::emit_req_t       req,
  input  wire itp_pkg::emit_stat_t stat
);
  import itp_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t       state, state_next;
  logic [CW-1:0] count, count_next;
  status_t      err, err_next;
  logic [7:0]   sym;
  logic         is_end;
  kind_t        kind;
  kind_t        in_kind;
  logic [CW-1:0] count_dec;
  logic         can_prod;
  logic         is_muldiv_top;

  assign in_kind       = classify(in_symbol);
  assign count_dec     = count - CW'(1);
  assign can_prod      = !stat.hold_valid || stat.can_emit;
  assign is_muldiv_top = (rd_data == CH_MUL) || (rd_data == CH_DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      err   <= ST_OK;
    end else begin
      state <= state_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sym    <= in_symbol;
      is_end <= in_end;
      kind   <= in_kind;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    err_next   = err;
    in_ready   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    wr_data    = sym;
    rd_en      = 1'b0;
    rd_addr    = count_dec[AW-1:0];
    req        = '0;
    req.res    = '{sym: rd_data, sym_valid: 1'b1, done: 1'b0, status: ST_OK};

    unique case (state)
      S_IDLE: begin
        // The hold register is always empty here.
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_kind)
            K_LETTER: begin
              req.produce = 1'b1;
              req.res.sym = in_symbol;
              state_next  = in_end ? S_FLUSH_READ : S_FINISH;
            end
            K_OPEN:                     state_next = S_PUSH;
            K_CLOSE, K_MULDIV, K_ADDSUB: state_next = S_READ;
            default:                    state_next = in_end ? S_FLUSH_READ : S_FINISH;
          endcase
        end
      end

      S_PUSH: begin
        if (count < CW'(DEPTH)) begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end else if (err == ST_OK) begin
          err_next = ST_OVERFLOW;
        end
        state_next = is_end ? S_FLUSH_READ : S_FINISH;
      end

      S_READ: begin
        if (count == '0) begin
          if (kind == K_CLOSE) begin
            if (err == ST_OK) err_next = ST_UNMATCHED;
            state_next = is_end ? S_FLUSH_READ : S_FINISH;
          end else begin
            state_next = S_PUSH;
          end
        end else begin
          rd_en      = 1'b1;
          state_next = S_TEST;
        end
      end

      S_TEST: begin
        if (kind == K_CLOSE && rd_data == CH_OPEN) begin
          // Matching bracket is dropped and the scan ends.
          count_next = count_dec;
          state_next = is_end ? S_FLUSH_READ : S_FINISH;
        end else if ((kind == K_MULDIV && !is_muldiv_top) ||
                     (kind == K_ADDSUB && rd_data == CH_OPEN)) begin
          state_next = S_PUSH;
        end else if (can_prod) begin
          req.produce = 1'b1;
          count_next  = count_dec;
          state_next  = S_READ;
        end
      end

      S_FLUSH_READ: begin
        if (count == '0) begin
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_FLUSH_TEST;
        end
      end

      S_FLUSH_TEST: begin
        if (rd_data == CH_OPEN) begin
          count_next = count_dec;
          state_next = S_FLUSH_READ;
        end else if (can_prod) begin
          req.produce = 1'b1;
          count_next  = count_dec;
          state_next  = S_FLUSH_READ;
        end
      end

      S_DONE: begin
        if (can_prod) begin
          req.produce = 1'b1;
          req.res     = '{sym: 8'h00, sym_valid: 1'b0, done: 1'b1, status: err};
          count_next  = '0;
          err_next    = ST_OK;
          state_next  = S_FINISH;
        end
      end

      S_FINISH: begin
        req.finish = 1'b1;
        if (!stat.hold_valid || stat.can_emit) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/infix_to_postfix_converter.sv */
// A letter's result goes to the hold register, then to the output register when that can take it.
// Only idle accepts a character. A letter or ignored character passes idle and finish, a '(' idle,
// push and finish, an operator idle, the stack walk, a push and finish, a ')' idle, the walk and
// finish. Each stack entry examined takes a memory read, then a test of the registered top that
// waits while the output is full; the end of an expression adds the flush walk and the done state.
// Synchronous reset clears the sequencer, stack count and error; stack memory is not cleared.
`default_nettype none
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  wire logic       s_axis_tlast,   // end_of_expr
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // [7:0] out_symbol
  output logic            m_axis_tlast,   // last
  output logic      [3:0] m_axis_tuser    // [0] symbol_valid, [1] done_res, [3:2] status
);
  import itp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  emit_req_t     req;
  emit_stat_t    stat;
  result_t       out_res;

  itp_ctrl #(.DEPTH(STACK_DEPTH), .AW(AW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_symbol(s_axis_tdata),
    .in_end   (s_axis_tlast),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .req      (req),
    .stat     (stat)
  );

  itp_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  itp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .stat     (stat),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = out_res.sym;
  assign m_axis_tuser = {out_res.status, out_res.done, out_res.sym_valid};

endmodule
`default_nettype wire

/* design/itp_checker.sv */
// Port-level checks for the infix to postfix converter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module itp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast,
  input wire logic [3:0] m_axis_tuser
);

  // A stalled result keeps its contents until it is taken.
  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output changed")

  // The done result closes its item.
  `ASSERT_CLK(a_done_last, clk, rst, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast, "done result without last")

  // A result carries a character or is the done result, never both.
  `ASSERT_CLK(a_kind_excl, clk, rst, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]), "symbol and done both set")

  // Status is reported only on the done result.
  `ASSERT_CLK(a_status_done, clk, rst, m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tuser[3:2] == 2'd0, "status outside done result")

  // Items are worked one at a time: no transfer directly after another.
  `ASSERT_CLK(a_one_item, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")

endmodule

bind infix_to_postfix_converter itp_checker u_chk (.*);
`default_nettype wire
